// ===== design/hpq_pkg.sv =====
package hpq_pkg;

   localparam int unsigned KeyWidth      = 31;
   localparam int unsigned SelWidth      = 7;
   localparam int unsigned CountWidth    = 3;
   localparam int unsigned SizeWidth     = 8;
   localparam int unsigned HomeWidth     = 4;
   localparam int unsigned SumWidth      = 12;
   localparam int unsigned DistWidth     = 4;
   localparam int unsigned FuncWidth     = 2;

   localparam int unsigned HomeModulus   = 11;
   localparam int unsigned ProbeSlots    = 7;
   localparam int unsigned StepNear      = 1;
   localparam int unsigned StepMid       = 4;
   localparam int unsigned StepFar       = 9;
   localparam int unsigned TableSizeInit = 16;
   localparam int unsigned QueueDepth    = 2;

   localparam int unsigned RecipShift    = 11;
   localparam int unsigned RecipMult     = (2 ** RecipShift) / HomeModulus;

   localparam logic [FuncWidth-1:0] FUNC_INSERT = 2'd0;
   localparam logic [FuncWidth-1:0] FUNC_SEARCH = 2'd1;
   localparam logic [FuncWidth-1:0] FUNC_CLEAR  = 2'd2;
   localparam logic [FuncWidth-1:0] FUNC_READ   = 2'd3;

   typedef enum logic [2:0] {
      OP_INSERT,
      OP_SEARCH,
      OP_CLEAR,
      OP_READ,
      OP_NULL
   } hpq_op_type;

   typedef enum logic [2:0] {
      BK_SWEEP,
      BK_IDLE,
      BK_PROBE,
      BK_READ,
      BK_DONE
   } hpq_back_state_type;

   typedef struct packed {
      hpq_op_type            op;
      logic [KeyWidth-1:0]   key;
      logic [HomeWidth-1:0]  home;
      logic [SelWidth-1:0]   sel;
   } hpq_entry_type;

   typedef struct packed {
      logic                  success;
      logic [CountWidth-1:0] probe_count;
      logic [SelWidth-1:0]   slot_position;
      logic [KeyWidth-1:0]   slot_value;
   } hpq_result_type;

   // 1024 is 1 modulo 11, so the 10-bit digits of the key sum to the same residue
   function automatic logic [SumWidth-1:0] hpq_fold(input logic [KeyWidth-1:0] key);
      return SumWidth'(key[9:0]) + SumWidth'(key[19:10]) + SumWidth'(key[29:20])
           + SumWidth'(key[30]);
   endfunction

   function automatic logic [HomeWidth-1:0] hpq_mod11(input logic [SumWidth-1:0] s);
      logic [SumWidth+7:0]         prod;
      logic [SumWidth+7-RecipShift:0] quot;
      logic [SumWidth-1:0]         rem;
      prod = s * 8'(RecipMult);
      quot = prod[SumWidth+7:RecipShift];
      rem  = s - (SumWidth'(quot) * SumWidth'(HomeModulus));
      if (rem >= SumWidth'(HomeModulus)) begin
         rem = rem - SumWidth'(HomeModulus);
      end
      return HomeWidth'(rem);
   endfunction

endpackage

// ===== design/hpq_req_if.sv =====
interface hpq_req_if
   import hpq_pkg::*;
();
   logic                 valid;
   logic                 ready;
   logic [FuncWidth-1:0] func;
   logic [KeyWidth-1:0]  key_value;
   logic [SelWidth-1:0]  slot_select;

   modport source (output valid, output func, output key_value, output slot_select,
                   input ready);
   modport sink   (input valid, input func, input key_value, input slot_select,
                   output ready);
endinterface

// ===== design/hpq_rsp_if.sv =====
interface hpq_rsp_if
   import hpq_pkg::*;
();
   logic                  valid;
   logic                  ready;
   logic                  success;
   logic [CountWidth-1:0] probe_count;
   logic [SelWidth-1:0]   slot_position;
   logic [KeyWidth-1:0]   slot_value;

   modport source (output valid, output success, output probe_count, output slot_position,
                   output slot_value, input ready);
   modport sink   (input valid, input success, input probe_count, input slot_position,
                   input slot_value, output ready);
endinterface

// ===== design/hpq_csr_if.sv =====
interface hpq_csr_if
   import hpq_pkg::*;
();
   logic                 valid;
   logic                 ready;
   logic [SizeWidth-1:0] table_size;

   modport source (output valid, output table_size, input ready);
   modport sink   (input valid, input table_size, output ready);
endinterface

// ===== design/hpq_front.sv =====
module hpq_front
   import hpq_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          accept_en,
   hpq_req_if.sink       req_if,
   output logic          push_valid,
   output hpq_entry_type push_entry,
   input  logic          push_ready
);

   logic                 a_valid_ff, a_valid_in;
   logic [FuncWidth-1:0] a_func_ff;
   logic [KeyWidth-1:0]  a_key_ff;
   logic [SelWidth-1:0]  a_sel_ff;

   logic                 b_valid_ff, b_valid_in;
   hpq_op_type           b_op_ff;
   logic [KeyWidth-1:0]  b_key_ff;
   logic [SelWidth-1:0]  b_sel_ff;
   logic [SumWidth-1:0]  b_sum_ff;

   logic                 a_adv, b_adv, a_take;
   hpq_op_type           a_op;

   assign b_adv        = !b_valid_ff || push_ready;
   assign a_adv        = a_valid_ff && b_adv;
   assign req_if.ready = accept_en && (!a_valid_ff || a_adv);
   assign a_take       = req_if.valid && req_if.ready;

   assign a_valid_in = a_take || (a_valid_ff && !a_adv);
   assign b_valid_in = a_adv || (b_valid_ff && !push_ready);

   always_comb begin
      case (a_func_ff)
         FUNC_INSERT: a_op = (a_key_ff == '0) ? OP_NULL : OP_INSERT;
         FUNC_SEARCH: a_op = (a_key_ff == '0) ? OP_NULL : OP_SEARCH;
         FUNC_CLEAR:  a_op = OP_CLEAR;
         FUNC_READ:   a_op = OP_READ;
         default:     a_op = OP_NULL;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (a_take) begin
         a_func_ff <= req_if.func;
         a_key_ff  <= req_if.key_value;
         a_sel_ff  <= req_if.slot_select;
      end
      if (a_adv) begin
         b_op_ff  <= a_op;
         b_key_ff <= a_key_ff;
         b_sel_ff <= a_sel_ff;
         b_sum_ff <= hpq_fold(a_key_ff);
      end
   end

   assign push_valid      = b_valid_ff;
   assign push_entry.op   = b_op_ff;
   assign push_entry.key  = b_key_ff;
   assign push_entry.home = hpq_mod11(b_sum_ff);
   assign push_entry.sel  = b_sel_ff;

endmodule

// ===== design/hpq_queue.sv =====
module hpq_queue
   import hpq_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          push_valid,
   input  hpq_entry_type push_entry,
   output logic          push_ready,
   output logic          pop_valid,
   output hpq_entry_type pop_entry,
   input  logic          pop_ready
);

   localparam int unsigned PtrWidth   = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
   localparam int unsigned CountWidthQ = $clog2(QueueDepth + 1);
   localparam logic [PtrWidth-1:0]    LastPtr = PtrWidth'(QueueDepth - 1);
   localparam logic [CountWidthQ-1:0] Full    = CountWidthQ'(QueueDepth);

   hpq_entry_type          slots_ff [QueueDepth];
   logic [PtrWidth-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [CountWidthQ-1:0] count_ff;
   logic                   do_push, do_pop;

   assign push_ready = (count_ff != Full);
   assign pop_valid  = (count_ff != '0);
   assign pop_entry  = slots_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ===== design/hpq_back.sv =====
module hpq_back
   import hpq_pkg::*;
#(
   parameter int unsigned TABLE_DEPTH = 128
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [SizeWidth-1:0] size_in_use,
   input  logic                 pop_valid,
   input  hpq_entry_type        pop_entry,
   output logic                 pop_ready,
   output logic                 init_done,
   hpq_rsp_if.source            rsp_if
);

   localparam int unsigned AddrWidth = $clog2(TABLE_DEPTH);
   localparam int unsigned PosWidth  = SizeWidth + 1;
   localparam logic [AddrWidth-1:0]  LastAddr  = AddrWidth'(TABLE_DEPTH - 1);
   localparam logic [CountWidth-1:0] LastProbe = CountWidth'(ProbeSlots - 1);

   logic [KeyWidth-1:0]   mem [TABLE_DEPTH];
   logic [KeyWidth-1:0]   rd_data_ff;

   hpq_back_state_type    state_ff, state_in;
   logic                  init_done_ff;
   logic [AddrWidth-1:0]  sweep_ff;
   hpq_op_type            op_ff;
   logic [KeyWidth-1:0]   key_ff;
   logic [HomeWidth-1:0]  home_ff;
   logic [SelWidth-1:0]   sel_ff;
   logic [CountWidth-1:0] k_ff;
   logic [SizeWidth-1:0]  pos_ff;
   hpq_result_type        res_ff, res_in;
   logic                  out_valid_ff;
   hpq_result_type        out_ff;

   logic                  rd_en, wr_en;
   logic [AddrWidth-1:0]  rd_addr, wr_addr;
   logic [KeyWidth-1:0]   wr_data;
   logic                  take, last_sweep, out_free, out_load;
   logic                  slot_empty, slot_match, probe_stop, sel_in_range;
   logic [CountWidth-1:0] k_nx;
   logic [SizeWidth-1:0]  pos_nx;

   function automatic logic [SizeWidth-1:0] probe_pos(input logic [HomeWidth-1:0]  home,
                                                      input logic [CountWidth-1:0] k,
                                                      input logic [SizeWidth-1:0]  size);
      logic [DistWidth-1:0] step_len;
      logic                 down;
      logic [PosWidth-1:0]  t;
      case (k)
         3'd1, 3'd2: step_len = DistWidth'(StepNear);
         3'd3, 3'd4: step_len = DistWidth'(StepMid);
         3'd5, 3'd6: step_len = DistWidth'(StepFar);
         default:    step_len = '0;
      endcase
      down = !k[0] && (k != '0);
      if (down) begin
         t = PosWidth'(home) + PosWidth'(size) - PosWidth'(step_len);
      end else begin
         t = PosWidth'(home) + PosWidth'(step_len);
      end
      if (t >= PosWidth'(size)) begin
         t = t - PosWidth'(size);
      end
      return SizeWidth'(t);
   endfunction

   assign take         = (state_ff == BK_IDLE) && pop_valid;
   assign last_sweep   = (sweep_ff == LastAddr);
   assign out_free     = !out_valid_ff || rsp_if.ready;
   assign out_load     = (state_ff == BK_DONE) && out_free;
   assign slot_empty   = (rd_data_ff == '0);
   assign slot_match   = (rd_data_ff == key_ff);
   assign probe_stop   = slot_empty || ((op_ff == OP_SEARCH) && slot_match) || (k_ff == LastProbe);
   assign sel_in_range = (32'(sel_ff) < TABLE_DEPTH);
   assign k_nx         = k_ff + 1'b1;
   assign pos_nx       = probe_pos(home_ff, k_nx, size_in_use);
   assign init_done    = init_done_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_SWEEP: begin
            if (last_sweep) begin
               state_in = init_done_ff ? BK_DONE : BK_IDLE;
            end
         end
         BK_IDLE: begin
            if (pop_valid) begin
               case (pop_entry.op)
                  OP_INSERT, OP_SEARCH: state_in = BK_PROBE;
                  OP_READ:              state_in = BK_READ;
                  OP_CLEAR:             state_in = BK_SWEEP;
                  default:              state_in = BK_DONE;
               endcase
            end
         end
         BK_PROBE: begin
            if (probe_stop) begin
               state_in = BK_DONE;
            end
         end
         BK_READ: state_in = BK_DONE;
         BK_DONE: begin
            if (out_free) begin
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_comb begin
      pop_ready = 1'b0;
      rd_en     = 1'b0;
      rd_addr   = AddrWidth'(pop_entry.home);
      wr_en     = 1'b0;
      wr_addr   = sweep_ff;
      wr_data   = '0;
      res_in    = res_ff;
      case (state_ff)
         BK_SWEEP: wr_en = 1'b1;
         BK_IDLE: begin
            pop_ready = 1'b1;
            if (pop_valid) begin
               rd_en  = 1'b1;
               res_in = '0;
               if (pop_entry.op == OP_READ) begin
                  rd_addr = AddrWidth'(pop_entry.sel);
               end
            end
         end
         BK_PROBE: begin
            if (probe_stop) begin
               res_in.probe_count = k_nx;
               if ((op_ff == OP_INSERT) && slot_empty) begin
                  wr_en                = 1'b1;
                  wr_addr              = AddrWidth'(pos_ff);
                  wr_data              = key_ff;
                  res_in.success       = 1'b1;
                  res_in.slot_position = SelWidth'(pos_ff);
               end else if ((op_ff == OP_SEARCH) && !slot_empty && slot_match) begin
                  res_in.success       = 1'b1;
                  res_in.slot_position = SelWidth'(pos_ff);
               end
            end else begin
               rd_en   = 1'b1;
               rd_addr = AddrWidth'(pos_nx);
            end
         end
         BK_READ: begin
            res_in.slot_position = sel_ff;
            res_in.slot_value    = sel_in_range ? rd_data_ff : '0;
         end
         BK_DONE: ;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_SWEEP;
         init_done_ff <= 1'b0;
         sweep_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == BK_SWEEP) begin
            sweep_ff <= last_sweep ? '0 : sweep_ff + 1'b1;
            if (last_sweep) begin
               init_done_ff <= 1'b1;
            end
         end
         if (out_load) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
      if (take) begin
         op_ff   <= pop_entry.op;
         key_ff  <= pop_entry.key;
         home_ff <= pop_entry.home;
         sel_ff  <= pop_entry.sel;
         k_ff    <= '0;
         pos_ff  <= SizeWidth'(pop_entry.home);
      end else if ((state_ff == BK_PROBE) && !probe_stop) begin
         k_ff   <= k_nx;
         pos_ff <= pos_nx;
      end
      if (out_load) begin
         out_ff <= res_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rsp_if.valid         = out_valid_ff;
   assign rsp_if.success       = out_ff.success;
   assign rsp_if.probe_count   = out_ff.probe_count;
   assign rsp_if.slot_position = out_ff.slot_position;
   assign rsp_if.slot_value    = out_ff.slot_value;

endmodule

// ===== design/hash_table_quadratic_probe_unit.sv =====
// Open-addressing hash table with quadratic probing over a TABLE_DEPTH-entry memory.
// req_if carries one operation per transaction: insert, search, clear or read slot.
// rsp_if returns exactly one result transaction per request, in request order.
// csr_if writes table_size, the wrap modulus (clamped to 11..TABLE_DEPTH); write it
// only while no request is outstanding.
// Requests pass a two-stage classifier (home slot = key mod 11), a two-entry queue,
// then the probe engine, which reads one memory slot per cycle.
// The engine serves one request at a time: insert or search makes n probes (1..7), read
// slot one memory read, key zero no probe, clear a pass over all TABLE_DEPTH slots; the
// single memory port sets this.
// The response is held in an output register; while the receiver stalls, the queue
// and classifier keep taking requests until they fill, then req_if.ready drops.
// Reset (synchronous, active high) sets table_size to 16 and starts a clearing pass
// over all TABLE_DEPTH slots, while req_if.ready stays low; csr_if is always ready.
module hash_table_quadratic_probe_unit
   import hpq_pkg::*;
#(
   parameter int unsigned TABLE_DEPTH = 128
) (
   input  logic      clock,
   input  logic      reset,
   hpq_csr_if.sink   csr_if,
   hpq_req_if.sink   req_if,
   hpq_rsp_if.source rsp_if
);

   localparam logic [SizeWidth-1:0] SizeCap =
      (TABLE_DEPTH >= (2 ** SizeWidth)) ? '1 : SizeWidth'(TABLE_DEPTH);
   localparam logic [SizeWidth-1:0] SizeFloor = SizeWidth'(HomeModulus);

   logic [SizeWidth-1:0] table_size_ff;
   logic [SizeWidth-1:0] size_ff, size_in;
   logic                 accept_en;
   logic                 push_valid, push_ready, pop_valid, pop_ready;
   hpq_entry_type        push_entry, pop_entry;

   assign csr_if.ready = 1'b1;

   always_comb begin
      if (table_size_ff < SizeFloor) begin
         size_in = SizeFloor;
      end else if (table_size_ff > SizeCap) begin
         size_in = SizeCap;
      end else begin
         size_in = table_size_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         table_size_ff <= SizeWidth'(TableSizeInit);
      end else if (csr_if.valid) begin
         table_size_ff <= csr_if.table_size;
      end
   end

   always_ff @(posedge clock) begin
      size_ff <= size_in;
   end

   hpq_front u_front (
      .clock      (clock),
      .reset      (reset),
      .accept_en  (accept_en),
      .req_if     (req_if),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .push_ready (push_ready)
   );

   hpq_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_entry  (pop_entry),
      .pop_ready  (pop_ready)
   );

   hpq_back #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .size_in_use (size_ff),
      .pop_valid   (pop_valid),
      .pop_entry   (pop_entry),
      .pop_ready   (pop_ready),
      .init_done   (accept_en),
      .rsp_if      (rsp_if)
   );

endmodule

// ===== design/hpq_checker.sv =====
module hpq_checker
   import hpq_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic                  rsp_success,
   input logic [CountWidth-1:0] rsp_probe_count,
   input logic [SelWidth-1:0]   rsp_slot_position,
   input logic [KeyWidth-1:0]   rsp_slot_value
);

   a_reset_blocks_req: assert property (@(posedge clock) reset |=> !req_ready)
      else $error("request accepted during clearing pass after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_success)
         && $stable(rsp_probe_count) && $stable(rsp_slot_position) && $stable(rsp_slot_value))
      else $error("stalled response changed");

   a_hit_probed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_success |-> rsp_probe_count != '0 && rsp_slot_value == '0)
      else $error("successful insert or search without a probe");

   a_value_only_read: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_slot_value != '0 |-> rsp_probe_count == '0 && !rsp_success)
      else $error("slot value on a response other than read");

   a_miss_position: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_success && rsp_probe_count != '0 |-> rsp_slot_position == '0)
      else $error("miss reported a slot position");

endmodule

bind hash_table_quadratic_probe_unit hpq_checker u_hpq_checker (
   .clock             (clock),
   .reset             (reset),
   .req_ready         (req_if.ready),
   .rsp_valid         (rsp_if.valid),
   .rsp_ready         (rsp_if.ready),
   .rsp_success       (rsp_if.success),
   .rsp_probe_count   (rsp_if.probe_count),
   .rsp_slot_position (rsp_if.slot_position),
   .rsp_slot_value    (rsp_if.slot_value)
);

// ===== tb/hash_table_quadratic_probe_unit_tb.sv =====
module hash_table_quadratic_probe_unit_tb;
   import hpq_pkg::*;

   localparam int unsigned TableDepth = 128;
   localparam int unsigned StallLimit = 4000;
   localparam int unsigned PhaseItems = 128;
   localparam int unsigned PhaseCount = 10;
   localparam int unsigned PoolKeys   = 24;
   localparam int unsigned DrainWait  = 150;

   typedef enum logic {
      ENTRY_OP,
      ENTRY_SIZE
   } entry_kind_type;

   typedef struct {
      entry_kind_type       kind;
      logic [FuncWidth-1:0] func;
      logic [KeyWidth-1:0]  key;
      logic [SelWidth-1:0]  sel;
      logic [SizeWidth-1:0] size;
   } table_op_type;

   logic clock = 1'b0;
   logic reset;

   hpq_csr_if csr_if ();
   hpq_req_if req_if ();
   hpq_rsp_if rsp_if ();

   hash_table_quadratic_probe_unit #(
      .TABLE_DEPTH (TableDepth)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .csr_if (csr_if),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   logic [KeyWidth-1:0]  slot_image [TableDepth];
   logic [SizeWidth-1:0] size_image;
   table_op_type         pending_ops [$];
   hpq_result_type       expected_results [$];
   table_op_type         held_op;
   hpq_result_type       predicted;
   hpq_result_type       wanted;

   int unsigned burst_left;
   int unsigned gap_left;
   int unsigned idle_cycles;
   int unsigned pattern_cnt;
   int unsigned stall_mode;
   int unsigned mismatches = 0;
   int unsigned results_seen = 0;
   int unsigned found_or_stored = 0;
   int unsigned full_paths = 0;
   int unsigned other_misses = 0;
   int unsigned slot_reads = 0;
   int unsigned table_clears = 0;
   int unsigned size_writes = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic hpq_result_type apply_table_op(input table_op_type op);
      hpq_result_type res;
      int unsigned    span;
      int unsigned    home;
      int unsigned    step_len;
      int unsigned    pos;
      logic           done;
      res  = '0;
      done = 1'b0;
      span = size_image;
      if (span > TableDepth) span = TableDepth;
      if (span < HomeModulus) span = HomeModulus;
      case (op.func)
         FUNC_CLEAR: begin
            foreach (slot_image[i]) slot_image[i] = '0;
         end
         FUNC_READ: begin
            res.slot_position = op.sel;
            if (op.sel < TableDepth) res.slot_value = slot_image[op.sel];
         end
         default: begin
            home = op.key % HomeModulus;
            for (int k = 0; k < ProbeSlots && op.key != '0 && !done; k++) begin
               step_len = (k == 0) ? 0 : (k < 3) ? StepNear : (k < 5) ? StepMid : StepFar;
               pos  = (k != 0 && k % 2 == 0) ? (home + span - step_len) % span
                                             : (home + step_len) % span;
               res.probe_count = res.probe_count + 1'b1;
               if (op.func == FUNC_INSERT && slot_image[pos] == '0) begin
                  slot_image[pos]   = op.key;
                  res.success       = 1'b1;
                  res.slot_position = SelWidth'(pos);
                  done              = 1'b1;
               end else if (op.func == FUNC_SEARCH && slot_image[pos] == '0) begin
                  done = 1'b1;
               end else if (op.func == FUNC_SEARCH && slot_image[pos] == op.key) begin
                  res.success       = 1'b1;
                  res.slot_position = SelWidth'(pos);
                  done              = 1'b1;
               end
            end
         end
      endcase
      return res;
   endfunction

   function automatic void queue_op(input logic [FuncWidth-1:0] func,
                                    input logic [KeyWidth-1:0]  key,
                                    input logic [SelWidth-1:0]  sel);
      table_op_type op;
      op.kind = ENTRY_OP;
      op.func = func;
      op.key  = key;
      op.sel  = sel;
      op.size = '0;
      pending_ops.push_back(op);
   endfunction

   function automatic void queue_size_write(input logic [SizeWidth-1:0] size);
      table_op_type op;
      op.kind = ENTRY_SIZE;
      op.func = FUNC_INSERT;
      op.key  = '0;
      op.sel  = '0;
      op.size = size;
      pending_ops.push_back(op);
   endfunction

   task automatic check_field(input string field, input logic [KeyWidth-1:0] want,
                              input logic [KeyWidth-1:0] got);
      if (want !== got) begin
         mismatches++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      end
   endtask

   // driver: one request transaction or one size write at a time
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         csr_if.valid <= 1'b0;
         foreach (slot_image[i]) slot_image[i] = '0;
         size_image = SizeWidth'(TableSizeInit);
         burst_left = $urandom_range(1, 48);
         gap_left   = 0;
      end else begin
         if (csr_if.valid && csr_if.ready) begin
            size_image = csr_if.table_size;
            size_writes++;
            csr_if.valid <= 1'b0;
         end
         if (req_if.valid && req_if.ready) begin
            predicted = apply_table_op(held_op);
            expected_results.push_back(predicted);
            case (held_op.func)
               FUNC_CLEAR: table_clears++;
               FUNC_READ:  slot_reads++;
               default: begin
                  if (predicted.success) found_or_stored++;
                  else if (predicted.probe_count == ProbeSlots) full_paths++;
                  else other_misses++;
               end
            endcase
            burst_left--;
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 48);
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 16);
            end
         end
         if (!req_if.valid || req_if.ready) begin
            if (gap_left != 0) begin
               gap_left--;
               req_if.valid <= 1'b0;
            end else if (pending_ops.size() != 0 && pending_ops[0].kind == ENTRY_OP
                         && !csr_if.valid) begin
               held_op = pending_ops.pop_front();
               req_if.valid       <= 1'b1;
               req_if.func        <= held_op.func;
               req_if.key_value   <= held_op.key;
               req_if.slot_select <= held_op.sel;
            end else begin
               req_if.valid <= 1'b0;
               // hold the size write until every outstanding transaction has returned
               if (pending_ops.size() != 0 && pending_ops[0].kind == ENTRY_SIZE
                   && !csr_if.valid && !req_if.valid && expected_results.size() == 0) begin
                  csr_if.table_size <= pending_ops[0].size;
                  csr_if.valid      <= 1'b1;
                  pending_ops.delete(0);
               end
            end
         end
      end
   end

   // monitor and receiver back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         pattern_cnt = 0;
         stall_mode  = 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            results_seen++;
            if (expected_results.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected result, expected none, actual %0d/%0d/%0d/%0d",
                        $time, rsp_if.success, rsp_if.probe_count, rsp_if.slot_position,
                        rsp_if.slot_value);
            end else begin
               wanted = expected_results.pop_front();
               check_field("success", KeyWidth'(wanted.success), KeyWidth'(rsp_if.success));
               check_field("probe_count", KeyWidth'(wanted.probe_count),
                           KeyWidth'(rsp_if.probe_count));
               check_field("slot_position", KeyWidth'(wanted.slot_position),
                           KeyWidth'(rsp_if.slot_position));
               check_field("slot_value", wanted.slot_value, rsp_if.slot_value);
            end
         end
         pattern_cnt++;
         if (pattern_cnt % 128 == 0) stall_mode = $urandom_range(0, 3);
         case (stall_mode)
            0:       rsp_if.ready <= 1'b1;
            1:       rsp_if.ready <= ($urandom_range(0, 1) != 0);
            2:       rsp_if.ready <= (pattern_cnt % 32 >= 20);
            default: rsp_if.ready <= ($urandom_range(0, 7) == 0);
         endcase
      end
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)
          || (csr_if.valid && csr_if.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == StallLimit) begin
         $display("** hash_table_quadratic_probe_unit: FAILED **");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      logic [KeyWidth-1:0]  key_pool [PoolKeys];
      logic [SizeWidth-1:0] phase_size [PhaseCount];
      logic [KeyWidth-1:0]  key;
      logic [FuncWidth-1:0] func;
      int unsigned          roll;

      reset              = 1'b1;
      req_if.valid       = 1'b0;
      req_if.func        = FUNC_INSERT;
      req_if.key_value   = '0;
      req_if.slot_select = '0;
      csr_if.valid       = 1'b0;
      csr_if.table_size  = SizeWidth'(TableSizeInit);
      rsp_if.ready       = 1'b0;
      idle_cycles        = 0;

      queue_op(FUNC_INSERT, 31'd27, 7'd0);
      queue_op(FUNC_SEARCH, 31'd27, 7'd0);
      queue_op(FUNC_CLEAR, 31'd0, 7'd0);
      queue_size_write(8'd11);
      queue_op(FUNC_SEARCH, 31'd5, 7'd0);
      queue_op(FUNC_INSERT, 31'd0, 7'd0);
      queue_op(FUNC_SEARCH, 31'd0, 7'd0);
      // fill the whole path of home slot zero
      for (int m = 1; m <= 7; m++) queue_op(FUNC_INSERT, KeyWidth'(11 * m), 7'd0);
      queue_op(FUNC_INSERT, 31'd88, 7'd0);
      queue_op(FUNC_SEARCH, 31'd77, 7'd0);
      queue_op(FUNC_SEARCH, 31'd88, 7'd0);
      queue_op(FUNC_INSERT, 31'd1, 7'd0);
      queue_op(FUNC_INSERT, 31'd1, 7'd0);
      queue_op(FUNC_READ, 31'd0, 7'd0);
      queue_op(FUNC_READ, 31'h7FFF_FFFF, 7'd127);
      queue_op(FUNC_INSERT, 31'h7FFF_FFFF, 7'd0);
      queue_op(FUNC_SEARCH, 31'h7FFF_FFFF, 7'd0);
      queue_op(FUNC_CLEAR, 31'd0, 7'd0);
      queue_op(FUNC_READ, 31'd0, 7'd0);
      queue_op(FUNC_SEARCH, 31'd11, 7'd0);

      phase_size = '{8'd0, 8'd255, 8'd128, 8'd11, 8'd129, 8'd10, 8'd12, 8'd64, 8'd0, 8'd0};
      phase_size[8] = SizeWidth'($urandom_range(HomeModulus, TableDepth));
      phase_size[9] = SizeWidth'($urandom_range(0, 255));
      for (int p = 0; p < PhaseCount; p++) begin
         queue_size_write(phase_size[p]);
         foreach (key_pool[i]) begin
            key_pool[i] = KeyWidth'($urandom());
            if (key_pool[i] == '0) key_pool[i] = 31'd1;
         end
         for (int n = 0; n < PhaseItems; n++) begin
            roll = $urandom_range(0, 99);
            func = (roll < 42) ? FUNC_INSERT : (roll < 78) ? FUNC_SEARCH
                 : (roll < 98) ? FUNC_READ : FUNC_CLEAR;
            roll = $urandom_range(0, 99);
            if (roll < 72) key = key_pool[$urandom_range(0, PoolKeys - 1)];
            else if (roll < 77) key = '0;
            else key = KeyWidth'($urandom());
            queue_op(func, key, ($urandom_range(0, 1) != 0) ? SelWidth'($urandom())
                                                             : SelWidth'($urandom_range(0, 15)));
         end
      end

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      do @(posedge clock);
      while (pending_ops.size() != 0 || req_if.valid || csr_if.valid
             || expected_results.size() != 0);
      repeat (DrainWait) @(posedge clock);

      $display("Checked %0d results: %0d stored or found, %0d full paths, %0d other misses,",
               results_seen, found_or_stored, full_paths, other_misses);
      $display("%0d slot reads, %0d clears, across %0d table size settings",
               slot_reads, table_clears, size_writes);
      if (mismatches == 0) begin
         $display("** hash_table_quadratic_probe_unit: PASSED **");
      end else begin
         $display("** hash_table_quadratic_probe_unit: FAILED **");
      end
      $finish;
   end

endmodule
